### design/isa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and constants for the insertable shift array.
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int POS_W        = 7;
    localparam int DATA_W       = 32;

    // Command codes
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Shift operation broadcast to every cell
    typedef struct packed {
        logic ins;  // open a slot at the position and load the new value
        logic del;  // close the slot at the position
    } t_cell_op;

endpackage
`default_nettype wire

### design/isa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_cell
// One storage slot of the array. On insert, slots above the position take
// their lower neighbor and the slot at the position loads the new value; on
// delete, slots at and above the position take their upper neighbor.
// ----------------------------------------------------------------------------
module isa_cell #(
    parameter int CAPACITY = isa_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0
) (
    input  wire                                              i_clk,
    input  isa_pkg::t_cell_op                                i_op,
    input  wire [isa_pkg::POS_W+$clog2(CAPACITY+1)-1:0]      i_pos,
    input  wire [isa_pkg::DATA_W-1:0]                        i_value,
    input  wire [isa_pkg::DATA_W-1:0]                        i_left,
    input  wire [isa_pkg::DATA_W-1:0]                        i_right,
    output logic [isa_pkg::DATA_W-1:0]                       o_data
);
    import isa_pkg::*;

    localparam int EW = POS_W + $clog2(CAPACITY + 1);
    localparam logic [EW-1:0] MY_IDX = EW'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Next slot content
    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (MY_IDX > i_pos) begin
                n_data = i_left;
            end else if (MY_IDX == i_pos) begin
                n_data = i_value;
            end
        end else if (i_op.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

### design/isa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isa_ctrl
// Command decode, bound and full checks, element count, read select and the
// result register.
// ----------------------------------------------------------------------------
module isa_ctrl #(
    parameter int CAPACITY = isa_pkg::DEF_CAPACITY
) (
    input  wire                                              i_clk,
    input  wire                                              i_rst_n,
    input  wire                                              i_req,
    input  wire [1:0]                                        i_cmd,
    input  wire [isa_pkg::POS_W-1:0]                         i_position,
    input  wire [isa_pkg::DATA_W-1:0]                        i_cell_data [CAPACITY],
    output isa_pkg::t_cell_op                                o_op,
    output logic [isa_pkg::POS_W+$clog2(CAPACITY+1)-1:0]     o_pos,
    output logic                                             o_valid,
    output logic [1:0]                                       o_status,
    output logic [isa_pkg::POS_W-1:0]                        o_count_after,
    output logic [isa_pkg::DATA_W-1:0]                       o_read_value
);
    import isa_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = POS_W + CW;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] n_rd;

    logic [EW-1:0] pos_x;
    logic [EW-1:0] cnt_x;
    logic          full;
    t_cmd          cmd;

    assign cmd   = t_cmd'(i_cmd);
    assign pos_x = EW'(i_position);
    assign cnt_x = EW'(r_count);
    assign full  = (r_count == CAP_C);

    // Decode and checks
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        n_rd     = '0;
        o_op     = '0;
        o_pos    = pos_x;
        case (cmd)
            CMD_APPEND: begin
                o_pos = cnt_x;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    o_op.ins = i_req;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_INSERT: begin
                if (pos_x > cnt_x) begin
                    n_status = ST_BOUND;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    o_op.ins = i_req;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (pos_x >= cnt_x) begin
                    n_status = ST_BOUND;
                end else begin
                    o_op.del = i_req;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                if (pos_x >= cnt_x) begin
                    n_status = ST_BOUND;
                end else begin
                    n_rd = i_cell_data[AW'(i_position)];
                end
            end
        endcase
    end

    // Count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req;
            if (i_req) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_count_after = POS_W'(r_count);
    assign o_read_value  = r_rd;

endmodule
`default_nettype wire

### design/insertable_shift_array.sv
`default_nettype none
// ----------------------------------------------------------------------------
// insertable_shift_array
// Ordered store of signed 32-bit elements with append, insert, delete and
// read commands, built as a row of shifting cells.
// The o_valid strobe for a request rises in the cycle after the request.
// Throughput: one request per cycle; busy is never raised since every cell
// shifts in parallel within the cycle of the request.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset clears the element count and the strobe; cell contents are kept.
// ----------------------------------------------------------------------------
module insertable_shift_array #(
    parameter int CAPACITY = isa_pkg::DEF_CAPACITY
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [1:0]                    i_cmd,
    input  wire [isa_pkg::POS_W-1:0]     i_position,
    input  wire signed [isa_pkg::DATA_W-1:0] i_value,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [isa_pkg::POS_W-1:0]    o_count_after,
    output logic signed [isa_pkg::DATA_W-1:0] o_read_value
);
    import isa_pkg::*;

    localparam int EW = POS_W + $clog2(CAPACITY + 1);

    logic              req;
    t_cell_op          op;
    logic [EW-1:0]     sel_pos;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] rd;

    assign busy = 1'b0;
    assign req  = start & ~busy;

    isa_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_cell_data   (cell_data),
        .o_op          (op),
        .o_pos         (sel_pos),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count_after (o_count_after),
        .o_read_value  (rd)
    );

    assign o_read_value = $signed(rd);

    // Row of cells, each wired to its lower and upper neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;

        if (g == 0) begin : g_lo
            assign left = '0;
        end else begin : g_lo
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_hi
            assign right = cell_data[g];
        end else begin : g_hi
            assign right = cell_data[g+1];
        end

        isa_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (op),
            .i_pos   (sel_pos),
            .i_value (i_value),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g])
        );
    end

endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for insertable_shift_array. Requests are driven on the
// falling edge, and a shadow copy of the array predicts status, count and
// read data for each accepted request. Every o_valid strobe is compared
// against the oldest outstanding reply. Directed cases cover the empty and
// full array and out-of-bound positions. Random traffic then walks the fill
// level up and down between empty and full, with sender idling in phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import isa_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    typedef struct packed {
        t_status                   status;
        logic [POS_W-1:0]          count;
        logic signed [DATA_W-1:0]  word;
    } t_reply;

    // DUT connections; the inputs are known from time zero
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 i_cmd = CMD_READ;
    logic [POS_W-1:0]           i_position = '0;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic                       o_valid;
    logic [1:0]                 o_status;
    logic [POS_W-1:0]           o_count_after;
    logic signed [DATA_W-1:0]   o_read_value;

    // Shadow copy of the array contents
    logic signed [DATA_W-1:0]   shadow_cells [CAP];
    int                         shadow_count = 0;

    t_reply                     outstanding_replies [$];
    int                         fail_count = 0;
    bit                         grow_phase = 1'b1;

    insertable_shift_array u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count_after (o_count_after),
        .o_read_value  (o_read_value)
    );

    // 125 MHz clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Apply one command to the shadow array and return the reply it owes
    function automatic t_reply apply_array_command(input t_cmd cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        t_reply r;
        int     p;
        int     slot;
        p = pos;
        r.status = ST_OK;
        r.word = '0;
        case (cmd)
            CMD_APPEND, CMD_INSERT: begin
                // position check wins over full
                if (cmd == CMD_INSERT && p > shadow_count) begin
                    r.status = ST_BOUND;
                end else if (shadow_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (cmd == CMD_APPEND) ? shadow_count : p;
                    for (int i = shadow_count; i > slot; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[slot] = val;
                    shadow_count++;
                end
            end
            CMD_DELETE: begin
                if (p >= shadow_count) begin
                    r.status = ST_BOUND;
                end else begin
                    for (int i = p + 1; i < shadow_count; i++)
                        shadow_cells[i-1] = shadow_cells[i];
                    shadow_count--;
                end
            end
            default: begin
                if (p >= shadow_count)
                    r.status = ST_BOUND;
                else
                    r.word = shadow_cells[p];
            end
        endcase
        r.count = shadow_count[POS_W-1:0];
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Drive one request and wait until it is taken
    task automatic send_request(input t_cmd cmd, input int pos,
                                input logic signed [DATA_W-1:0] val);
        t_reply r;
        @(negedge i_clk);
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos[POS_W-1:0];
        i_value    <= val;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        r = apply_array_command(cmd, pos[POS_W-1:0], val);
        outstanding_replies.push_back(r);
    endtask

    // Drop start for a short random gap
    task automatic pause_sender();
        @(negedge i_clk);
        start <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions up to the fill level, sometimes anywhere in the field
    function automatic int pick_position();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, shadow_count);
        return $urandom_range(0, 127);
    endfunction

    // Reply checker
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (outstanding_replies.size() == 0) begin
                note_failure($sformatf("reply with none outstanding: st=%0d cnt=%0d rd=%0h",
                                       o_status, o_count_after, o_read_value));
            end else begin
                want = outstanding_replies.pop_front();
                if (o_status !== want.status || o_count_after !== want.count ||
                    o_read_value !== want.word)
                    note_failure($sformatf("st %0d/%0d cnt %0d/%0d rd %0h/%0h (exp/act)",
                                           want.status, o_status, want.count,
                                           o_count_after, want.word, o_read_value));
            end
        end
    end

    // Read, delete and insert against an empty array
    task automatic test_empty_rejects();
        send_request(CMD_READ, 0, $urandom);
        send_request(CMD_DELETE, 0, $urandom);
        send_request(CMD_INSERT, 1, 32'sd5);
        send_request(CMD_READ, 127, $urandom);
    endtask

    // Appends, inserts at head, tail and middle, reads and deletes
    task automatic test_basic_edits();
        send_request(CMD_APPEND, 127, 32'sh7FFF_FFFF);
        send_request(CMD_APPEND, 0, 32'sh8000_0000);
        send_request(CMD_INSERT, 0, -32'sd1);
        send_request(CMD_INSERT, 3, 32'sd0);            // insert at count
        send_request(CMD_INSERT, 2, 32'sh5A5A_A5A5);
        send_request(CMD_INSERT, 6, 32'sd7);            // one past count
        for (int i = 0; i < 5; i++)
            send_request(CMD_READ, i, $urandom);
        send_request(CMD_DELETE, 2, $urandom);
        send_request(CMD_DELETE, 0, $urandom);
        send_request(CMD_DELETE, 2, $urandom);          // last element
        send_request(CMD_DELETE, 2, $urandom);          // equal to count
        send_request(CMD_READ, 127, $urandom);
    endtask

    // Fill to capacity, then rejections at the full array
    task automatic test_capacity_limit();
        while (shadow_count < CAP) begin
            send_request(CMD_APPEND, $urandom_range(0, 127), pick_value());
            if ($urandom_range(0, 9) == 0)
                send_request(CMD_READ, $urandom_range(0, shadow_count - 1), $urandom);
        end
        send_request(CMD_APPEND, 0, $urandom);
        send_request(CMD_INSERT, 10, $urandom);
        send_request(CMD_INSERT, CAP, $urandom);        // at count but full
        send_request(CMD_INSERT, CAP + 1, $urandom);    // beyond count
        send_request(CMD_INSERT, 127, $urandom);
        send_request(CMD_READ, CAP - 1, $urandom);
        send_request(CMD_READ, CAP, $urandom);
        send_request(CMD_DELETE, CAP - 1, $urandom);
        send_request(CMD_INSERT, CAP - 1, 32'sh8000_0000);
        send_request(CMD_READ, CAP - 1, $urandom);
    endtask

    // Random traffic that drifts the fill level between empty and full
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int   roll;
        t_cmd cmd;
        for (int n = 0; n < n_items; n++) begin
            if (shadow_count >= CAP)
                grow_phase = 1'b0;
            else if (shadow_count == 0)
                grow_phase = 1'b1;
            else if ($urandom_range(0, 99) < 3)
                grow_phase = ~grow_phase;
            roll = $urandom_range(0, 99);
            if (grow_phase)
                cmd = (roll < 35) ? CMD_APPEND : (roll < 65) ? CMD_INSERT :
                      (roll < 80) ? CMD_DELETE : CMD_READ;
            else
                cmd = (roll < 10) ? CMD_APPEND : (roll < 25) ? CMD_INSERT :
                      (roll < 65) ? CMD_DELETE : CMD_READ;
            send_request(cmd, pick_position(), pick_value());
            if ($urandom_range(0, 99) < idle_pct)
                pause_sender();
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_rejects();
        test_basic_edits();
        test_capacity_limit();
        test_random_traffic(14, 170);
        test_random_traffic(60, 170);
        test_random_traffic(0, 170);

        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
